FILE: hw/rtl/cls_pkg.sv
// Shared types and constants for the command line normalizer and splitter.
package cls_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       line_last;
    } in_t;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       part;
        logic       line_end;
        logic [1:0] status;
    } out_t;

    // Up to two results produced by one input transaction
    typedef struct packed {
        logic [1:0] n_res;
        out_t       first;
        out_t       second;
    } push_t;

    // Line status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Register map (index = paddr[4:3])
    localparam int          ADDR_W       = 5;
    localparam logic [1:0]  REG_SEP_SET  = 2'd0;
    localparam logic [1:0]  REG_SEP_CNT  = 2'd1;
    localparam logic [1:0]  REG_MAX_LEN  = 2'd2;

    // Register reset values
    localparam logic [63:0] SEP_SET_RST  = 64'h0009_0D0A_2928_2C20;
    localparam logic [3:0]  SEP_CNT_RST  = 4'd7;
    localparam logic [11:0] MAX_LEN_RST  = 12'd64;

    // Character codes and limits
    localparam logic [7:0]  SPACE_BYTE   = 8'h20;
    localparam logic [7:0]  QUOTE_BYTE   = 8'h22;
    localparam int          SEP_SLOTS    = 8;
    localparam logic [12:0] MIN_LEN      = 13'd64;
    localparam int          MAX_LINE_DEF = 2048;

    // Result queue geometry
    localparam int          Q_DEPTH      = 4;
    localparam int          Q_PTR_W      = 2;
    localparam int          Q_CNT_W      = 3;

endpackage

FILE: hw/rtl/cls_norm.sv
// Line state tracking and per-byte normalization; yields up to two results per transaction.
module cls_norm #(
    parameter int MAX_LINE = cls_pkg::MAX_LINE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  cls_pkg::in_t     item,
    input  logic [63:0]      sep_set,
    input  logic [3:0]       sep_count,
    input  logic [11:0]      max_len,
    output cls_pkg::push_t   push
);

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam logic [12:0] MAX_L = 13'(MAX_LINE);

    logic             seen_reg, seen_next;
    logic             quoted_reg, quoted_next;
    logic             run_reg, run_next;
    logic             past_reg, past_next;
    logic             any_reg, any_next;
    logic             trunc_reg, trunc_next;
    logic [CNT_W-1:0] kept_reg, kept_next;

    logic [3:0]       slots;
    logic             sep_hit;
    logic [12:0]      len_clamped;
    logic [CNT_W-1:0] limit;
    logic             active;
    logic             is_sep;
    logic             emit;
    logic             take;
    logic [7:0]       nb;
    logic             char_out;
    cls_pkg::out_t    char_res;
    cls_pkg::out_t    end_res;

    // Separator match over the enabled slots
    always_comb
    begin
        slots   = (sep_count > 4'(cls_pkg::SEP_SLOTS)) ? 4'(cls_pkg::SEP_SLOTS) : sep_count;
        sep_hit = 1'b0;
        for (int k = 0; k < cls_pkg::SEP_SLOTS; k++)
        begin
            if ((4'(k) < slots) && (sep_set[8*k +: 8] == item.in_byte))
            begin
                sep_hit = 1'b1;
            end
        end
    end

    // Keep limit from the clamped buffer size
    always_comb
    begin
        len_clamped = {1'b0, max_len};
        if (len_clamped < cls_pkg::MIN_LEN)
        begin
            len_clamped = cls_pkg::MIN_LEN;
        end
        else if (len_clamped > MAX_L)
        begin
            len_clamped = MAX_L;
        end
        limit = CNT_W'(len_clamped - 13'd1);
    end

    // Next line state and results
    always_comb
    begin
        any_next    = any_reg | item.has_byte;
        seen_next   = seen_reg | (item.has_byte & (item.in_byte != cls_pkg::SPACE_BYTE));
        active      = item.has_byte & seen_next;
        quoted_next = quoted_reg ^ (active & (item.in_byte == cls_pkg::QUOTE_BYTE));
        is_sep      = active & ~quoted_next & sep_hit;
        run_next    = active ? is_sep : run_reg;
        emit        = active & ~(is_sep & run_reg);
        nb          = is_sep ? cls_pkg::SPACE_BYTE : item.in_byte;
        take        = emit & (kept_reg < limit);
        trunc_next  = trunc_reg | (emit & ~take);
        kept_next   = kept_reg + CNT_W'(take);
        char_out    = take & (past_reg | (nb != cls_pkg::SPACE_BYTE));
        past_next   = past_reg | (take & (nb == cls_pkg::SPACE_BYTE));

        char_res            = '0;
        char_res.out_byte   = nb;
        char_res.byte_valid = 1'b1;
        char_res.part       = past_reg;

        end_res          = '0;
        end_res.line_end = 1'b1;
        if (!any_next)
        begin
            end_res.status = cls_pkg::ST_EMPTY;
        end
        else if (trunc_next)
        begin
            end_res.status = cls_pkg::ST_TRUNC;
        end
        else
        begin
            end_res.status = cls_pkg::ST_OK;
        end

        push        = '0;
        push.second = end_res;
        if (accept)
        begin
            if (char_out)
            begin
                push.first = char_res;
                push.n_res = item.line_last ? 2'd2 : 2'd1;
            end
            else if (item.line_last)
            begin
                push.first = end_res;
                push.n_res = 2'd1;
            end
        end
    end

    // State registers; a line end clears everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            quoted_reg <= 1'b0;
            run_reg    <= 1'b0;
            past_reg   <= 1'b0;
            any_reg    <= 1'b0;
            trunc_reg  <= 1'b0;
            kept_reg   <= '0;
        end
        else if (accept)
        begin
            if (item.line_last)
            begin
                seen_reg   <= 1'b0;
                quoted_reg <= 1'b0;
                run_reg    <= 1'b0;
                past_reg   <= 1'b0;
                any_reg    <= 1'b0;
                trunc_reg  <= 1'b0;
                kept_reg   <= '0;
            end
            else
            begin
                seen_reg   <= seen_next;
                quoted_reg <= quoted_next;
                run_reg    <= run_next;
                past_reg   <= past_next;
                any_reg    <= any_next;
                trunc_reg  <= trunc_next;
                kept_reg   <= kept_next;
            end
        end
    end

    // A line end leaves the line state cleared
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.line_last) |=> (kept_reg == '0 && !past_reg && !any_reg && !quoted_reg))
        else $error("line state not cleared after line end");

    // The command word never carries a space
    a_cmd_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n_res != 2'd0 && push.first.byte_valid && !push.first.part)
            |-> (push.first.out_byte != cls_pkg::SPACE_BYTE))
        else $error("space emitted in command word");

    // Nothing is produced before the line has started
    a_no_lead_char: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !seen_reg && !(item.has_byte && item.in_byte != cls_pkg::SPACE_BYTE))
            |-> (push.n_res == 2'd0 || !push.first.byte_valid))
        else $error("character emitted from leading spaces");

endmodule

FILE: hw/rtl/cls_outq.sv
// Four-entry result queue: takes up to two a cycle, hands out one on out_ready.
module cls_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  cls_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output cls_pkg::out_t   out_data
);

    cls_pkg::out_t                mem_reg [cls_pkg::Q_DEPTH];
    logic [cls_pkg::Q_PTR_W-1:0]  wr_reg, wr_next;
    logic [cls_pkg::Q_PTR_W-1:0]  rd_reg, rd_next;
    logic [cls_pkg::Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign room      = (cnt_reg <= cls_pkg::Q_CNT_W'(cls_pkg::Q_DEPTH - 2));
    assign pop       = out_valid & out_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_next  = wr_reg + cls_pkg::Q_PTR_W'(push.n_res);
        rd_next  = rd_reg + cls_pkg::Q_PTR_W'(pop);
        cnt_next = cnt_reg + cls_pkg::Q_CNT_W'(push.n_res) - cls_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push.n_res != 2'd0)
        begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.n_res == 2'd2)
        begin
            mem_reg[wr_reg + cls_pkg::Q_PTR_W'(1)] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n_res != 2'd0) |-> (cnt_reg <= cls_pkg::Q_CNT_W'(cls_pkg::Q_DEPTH - 2)))
        else $error("result queue overflow");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cls_pkg::Q_CNT_W'(cls_pkg::Q_DEPTH))
        else $error("result queue count out of range");

    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.n_res == 2'd0) |=> (cnt_reg == $past(cnt_reg) - 3'd1))
        else $error("result queue count not decremented on pop");

endmodule

FILE: hw/rtl/command_line_normalizer_splitter.sv
// Command line normalizer and splitter: top level with register port.
//
// Input channel (in_valid/in_ready/in_data) carries one command-line byte per
// transaction, or an empty end marker (has_byte = 0); line_last closes a line.
// Output channel (out_valid/out_ready/out_data) carries normalized characters
// tagged as command word or parameter text, and one end result per line with
// its status (ok, empty line, truncated).
// Results of a transaction go into the result queue as it is accepted.
// Throughput: one transaction per cycle while in_ready is high; each yields
// at most two results, and the output side drains one per cycle while out_ready
// is high. The results sit in a four-entry queue; in_ready is high while the
// queue has at least two free entries, so a stalled receiver backs up into
// in_ready and nothing is lost.
// Separator set, separator count and buffer size: APB byte addresses 0, 8, 16.
// Write them only while the block is idle; the block does not enforce this.
// Reset (rst_n low) restores the register defaults, clears the line state and
// empties the result queue.
module command_line_normalizer_splitter #(
    parameter int MAX_LINE = cls_pkg::MAX_LINE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cls_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cls_pkg::out_t              out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cls_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);

    logic [63:0]     sep_set_reg;
    logic [3:0]      sep_cnt_reg;
    logic [11:0]     max_len_reg;
    logic [1:0]      reg_idx;
    logic            wr_en;
    logic            accept;
    logic            room;
    cls_pkg::push_t  push;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign in_ready = room;
    assign accept  = in_valid & in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_set_reg <= cls_pkg::SEP_SET_RST;
            sep_cnt_reg <= cls_pkg::SEP_CNT_RST;
            max_len_reg <= cls_pkg::MAX_LEN_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                cls_pkg::REG_SEP_SET: sep_set_reg <= pwdata;
                cls_pkg::REG_SEP_CNT: sep_cnt_reg <= pwdata[3:0];
                cls_pkg::REG_MAX_LEN: max_len_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            cls_pkg::REG_SEP_SET: prdata = sep_set_reg;
            cls_pkg::REG_SEP_CNT: prdata = {60'd0, sep_cnt_reg};
            cls_pkg::REG_MAX_LEN: prdata = {52'd0, max_len_reg};
            default:              prdata = '0;
        endcase
    end

    cls_norm #(
        .MAX_LINE (MAX_LINE)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_data),
        .sep_set   (sep_set_reg),
        .sep_count (sep_cnt_reg),
        .max_len   (max_len_reg),
        .push      (push)
    );

    cls_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
